### rtl/sfd_pkg.sv
// Shared types and constants for the serial bus frame decoder.
// Depends on nothing; used by sbus_frame_decoder and its testbench.
package sfd_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 25;
  localparam int POS_W       = 5;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
  localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'h00;

  // Channel result fields
  localparam int VALUE_W = 11;
  localparam int INDEX_W = 4;
  localparam logic [VALUE_W-1:0] VALUE_MASK = 11'h7FF;

  // Two frame banks, each addressed by the byte position
  localparam int RAM_ADDR_W = POS_W + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_ADDR_W;

  // Bit accumulator of the unpacker: holds at most the refill limit plus one byte
  localparam int REFILL_LIMIT = 15;
  localparam int ACC_W        = REFILL_LIMIT + BYTE_W;
  localparam int CNT_W        = 5;

  // Output word: channel_index from bit 0, channel_value above it, zero fill
  localparam int OUT_DATA_W = 16;

endpackage

### rtl/sfd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing; used for the frame store of the decoder.
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sbus_frame_decoder.sv
// Serial bus frame decoder top level: frame store, header check and channel unpacker.
// Depends on sfd_pkg and sfd_ram.
//
// Takes one received byte per cycle on the slave stream and counts bytes into
// 25-byte frames from reset, with no resynchronisation. A frame whose first byte
// is 0x0F and whose last byte is 0x00 yields NUM_CHANNELS words on the master
// stream, channel 0 first, tlast on the final channel. Frames are stored in two
// banks of one RAM, so the next frame is received while the previous one is
// unpacked. The unpacker reads one stored byte per cycle through the single RAM
// read port, the byte lands in the cycle after its read, and a read is only issued
// while the accumulator has room for it. Unpacking starts when the closing byte of
// a good frame is taken. Every byte is accepted in the cycle it is offered, except
// the closing byte of a frame, which waits while the previous frame is still being
// unpacked, a wait that stalls on the master side make longer.
module sbus_frame_decoder #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Slave stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sfd_pkg::BYTE_W-1:0]     s_tdata,  // [7:0] rx_byte
  // Master stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sfd_pkg::OUT_DATA_W-1:0] m_tdata,  // [3:0] channel_index,
                                                   // [14:4] channel_value, [15] zero
  output logic                           m_tlast   // last_channel
);

  localparam int LAST_BYTE = (sfd_pkg::VALUE_W * NUM_CHANNELS + sfd_pkg::BYTE_W - 1)
                             / sfd_pkg::BYTE_W;
  localparam logic [sfd_pkg::POS_W-1:0] LAST_POS =
    sfd_pkg::POS_W'(sfd_pkg::FRAME_BYTES - 1);
  localparam logic [sfd_pkg::POS_W-1:0] LAST_RD = sfd_pkg::POS_W'(LAST_BYTE);
  localparam logic [sfd_pkg::INDEX_W-1:0] LAST_CH = sfd_pkg::INDEX_W'(NUM_CHANNELS - 1);
  localparam logic [sfd_pkg::CNT_W-1:0] VAL_BITS = sfd_pkg::CNT_W'(sfd_pkg::VALUE_W);
  localparam logic [sfd_pkg::CNT_W-1:0] BYTE_BITS = sfd_pkg::CNT_W'(sfd_pkg::BYTE_W);
  localparam logic [sfd_pkg::CNT_W-1:0] REFILL = sfd_pkg::CNT_W'(sfd_pkg::REFILL_LIMIT);

  // Receive side
  logic [sfd_pkg::POS_W-1:0]   byte_position;
  logic                        wr_bank;
  logic                        hdr_ok;
  logic                        in_word;
  logic                        frame_start;

  // Unpack side
  logic                        busy;
  logic                        rd_bank;
  logic [sfd_pkg::POS_W-1:0]   rd_idx;
  logic                        rd_valid;
  logic                        rd_en;
  logic [sfd_pkg::BYTE_W-1:0]  rd_data;
  logic [sfd_pkg::ACC_W-1:0]   acc;
  logic [sfd_pkg::ACC_W-1:0]   acc_next;
  logic [sfd_pkg::ACC_W-1:0]   acc_shift;
  logic [sfd_pkg::CNT_W-1:0]   bit_count;
  logic [sfd_pkg::CNT_W-1:0]   bit_count_next;
  logic [sfd_pkg::CNT_W-1:0]   bit_rem;
  logic [sfd_pkg::INDEX_W-1:0] ch_idx;
  logic                        emit;

  // Output register
  logic [sfd_pkg::INDEX_W-1:0] out_index;
  logic [sfd_pkg::VALUE_W-1:0] out_value;

  // Hold back the closing byte while the other bank is still being unpacked
  assign s_tready    = !(busy && byte_position == LAST_POS);
  assign in_word     = s_tvalid && s_tready;
  assign frame_start = in_word && byte_position == LAST_POS && hdr_ok
                       && s_tdata == sfd_pkg::FOOTER_BYTE;

  // Frame store: write bank by receive side, read bank by unpacker
  sfd_ram #(
    .WIDTH (sfd_pkg::BYTE_W),
    .DEPTH (sfd_pkg::RAM_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (in_word),
    .waddr ({wr_bank, byte_position}),
    .wdata (s_tdata),
    .re    (rd_en),
    .raddr ({rd_bank, rd_idx}),
    .rdata (rd_data)
  );

  // Emit a channel once eleven bits are held and the output register is free
  assign emit = busy && bit_count >= VAL_BITS && (!m_tvalid || m_tready);

  // Drop emitted bits, append the byte landing from the RAM
  always_comb begin
    acc_shift = emit ? (acc >> sfd_pkg::VALUE_W) : acc;
    bit_rem   = emit ? (bit_count - VAL_BITS) : bit_count;
    if (rd_valid) begin
      acc_next       = acc_shift | (sfd_pkg::ACC_W'(rd_data) << bit_rem);
      bit_count_next = bit_rem + BYTE_BITS;
    end else begin
      acc_next       = acc_shift;
      bit_count_next = bit_rem;
    end
  end

  // Fetch the next byte while the accumulator has room for it
  assign rd_en = busy && rd_idx <= LAST_RD && bit_count_next <= REFILL;

  // Receive counter, bank swap and header flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      wr_bank       <= 1'b0;
      hdr_ok        <= 1'b0;
    end else if (in_word) begin
      if (byte_position == '0) begin
        hdr_ok <= s_tdata == sfd_pkg::HEADER_BYTE;
      end
      if (byte_position == LAST_POS) begin
        byte_position <= '0;
      end else begin
        byte_position <= byte_position + 1'b1;
      end
      if (frame_start) begin
        wr_bank <= !wr_bank;
      end
    end
  end

  // Unpacker control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rd_bank   <= 1'b0;
      rd_idx    <= '0;
      rd_valid  <= 1'b0;
      bit_count <= '0;
      ch_idx    <= '0;
    end else begin
      rd_valid <= rd_en;
      if (frame_start) begin
        busy      <= 1'b1;
        rd_bank   <= wr_bank;
        rd_idx    <= sfd_pkg::POS_W'(1);
        bit_count <= '0;
        ch_idx    <= '0;
      end else begin
        bit_count <= bit_count_next;
        if (rd_en) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (emit) begin
          ch_idx <= ch_idx + 1'b1;
          if (ch_idx == LAST_CH) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  // Accumulator payload: start each frame empty
  always_ff @(posedge clk) begin
    if (frame_start) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_index <= ch_idx;
      out_value <= acc[sfd_pkg::VALUE_W-1:0] & sfd_pkg::VALUE_MASK;
      m_tlast   <= ch_idx == LAST_CH;
    end
  end

  assign m_tdata = {1'b0, out_value, out_index};

  // Closing byte is never taken while a frame is still unpacking
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_word && byte_position == LAST_POS) |-> !busy)
    else $error("closing byte accepted during unpack");

  // Accumulator never overflows
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    bit_count <= sfd_pkg::CNT_W'(sfd_pkg::ACC_W))
    else $error("bit accumulator overflow");

  // RAM read data lands only while a frame is unpacking
  a_rd_in_frame: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> busy)
    else $error("stray frame store read");

  // Unpacker goes idle after the final channel is emitted
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && ch_idx == LAST_CH) |=> !busy)
    else $error("unpacker still busy after last channel");

endmodule

### verif/tb_sbus_frame_decoder.sv
// Self-checking testbench for sbus_frame_decoder: streams 25-byte frames in and
// checks every channel word against a frame-level predictor kept in a scoreboard.
// Depends on sfd_pkg and the sbus_frame_decoder RTL.
`timescale 1ns / 1ps

module tb_sbus_frame_decoder;

  localparam int CHANNELS    = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 50;
  localparam int RAND_FRAMES = 6;

  typedef struct packed {
    logic [sfd_pkg::INDEX_W-1:0] index;
    logic [sfd_pkg::VALUE_W-1:0] value;
    logic                        last;
  } chan_word_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_HEADER, FRAME_BAD_FOOTER, FRAME_NOISE} frame_kind_t;

  // Tracks the byte count and frame contents, and queues the channel words a
  // completed, well-formed frame should produce.
  class channel_scoreboard;
    logic [sfd_pkg::BYTE_W-1:0] frame_bytes [sfd_pkg::FRAME_BYTES];
    int unsigned       byte_slot = 0;
    chan_word_t        expected_q[$];
    int unsigned       errors = 0;
    int unsigned       words_checked = 0;
    int unsigned       frames_good = 0;
    int unsigned       frames_dropped = 0;

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_byte(logic [sfd_pkg::BYTE_W-1:0] b);
      logic [sfd_pkg::BYTE_W*(sfd_pkg::FRAME_BYTES-2)-1:0] payload;
      chan_word_t                                          w;
      int                                                  i;
      frame_bytes[byte_slot] = b;
      if (byte_slot != sfd_pkg::FRAME_BYTES - 1) begin
        byte_slot++;
        return;
      end
      byte_slot = 0;
      // Drop the frame on a bad header or footer
      if (frame_bytes[0] != sfd_pkg::HEADER_BYTE ||
          frame_bytes[sfd_pkg::FRAME_BYTES-1] != sfd_pkg::FOOTER_BYTE) begin
        frames_dropped++;
        return;
      end
      frames_good++;
      // Bytes 1 onward form one little-endian bit stream
      for (i = 1; i < sfd_pkg::FRAME_BYTES - 1; i++)
        payload[(i-1)*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = frame_bytes[i];
      for (i = 0; i < CHANNELS; i++) begin
        w.index = i[sfd_pkg::INDEX_W-1:0];
        w.value = payload[i*sfd_pkg::VALUE_W +: sfd_pkg::VALUE_W];
        w.last  = (i == CHANNELS - 1);
        expected_q.push_back(w);
      end
    endfunction

    function void check_channel(logic [sfd_pkg::OUT_DATA_W-1:0] data, logic last);
      chan_word_t exp_w;
      if (expected_q.size() == 0) begin
        $error("unexpected channel word: data 0x%04h, last %0b", data, last);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      words_checked++;
      if (data[sfd_pkg::INDEX_W-1:0] !== exp_w.index) begin
        $error("channel_index mismatch: expected %0d, actual %0d", exp_w.index,
               data[sfd_pkg::INDEX_W-1:0]);
        errors++;
      end
      if (data[sfd_pkg::INDEX_W +: sfd_pkg::VALUE_W] !== exp_w.value) begin
        $error("channel_value mismatch: expected %0d, actual %0d", exp_w.value,
               data[sfd_pkg::INDEX_W +: sfd_pkg::VALUE_W]);
        errors++;
      end
      if (last !== exp_w.last) begin
        $error("last_channel mismatch: expected %0b, actual %0b", exp_w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [sfd_pkg::BYTE_W-1:0]     s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [sfd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;

  channel_scoreboard sb = new;
  int unsigned       burst_left = 0;
  int unsigned       cycles = 0;
  bit [31:0]         stall_cycle = '0;

  sbus_frame_decoder #(
    .NUM_CHANNELS(CHANNELS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure: ready, random, short periodic and long stalls in turn
  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[7:6])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (stall_cycle[1:0] != 2'd0);
      default: m_tready <= stall_cycle[3];
    endcase
  end

  // Check each channel word as it leaves the block
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_channel(m_tdata, m_tlast);
  end

  // Offer one byte, inserting a random gap at the start of each burst
  task automatic push_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
  endtask

  // Hold the sender idle until every expected word has come out
  task automatic drain_outputs();
    @(negedge clk) s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [sfd_pkg::BYTE_W*(sfd_pkg::FRAME_BYTES-2)-1:0] bits;
    logic [sfd_pkg::BYTE_W-1:0]                          b;
    frame_kind_t                                         kind;
    int                                                  f;
    int                                                  i;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed frame: channels alternate between zero and full scale, flag byte all ones
    bits = '1;
    for (i = 0; i < CHANNELS; i++)
      bits[i*sfd_pkg::VALUE_W +: sfd_pkg::VALUE_W] = (i % 2 == 0) ? '0 : sfd_pkg::VALUE_MASK;
    push_byte(sfd_pkg::HEADER_BYTE);
    for (i = 1; i < sfd_pkg::FRAME_BYTES - 1; i++)
      push_byte(bits[(i-1)*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W]);
    push_byte(sfd_pkg::FOOTER_BYTE);
    drain_outputs();

    // Random frames: the first two broken, the rest mostly well formed, else broken or plain noise
    for (f = 0; f < RAND_FRAMES; f++) begin
      if (f == 0)
        kind = FRAME_BAD_HEADER;
      else if (f == 1)
        kind = FRAME_BAD_FOOTER;
      else
        case ($urandom_range(0, 9))
          0: kind = FRAME_BAD_HEADER;
          1: kind = FRAME_BAD_FOOTER;
          2: kind = FRAME_NOISE;
          default: kind = FRAME_GOOD;
        endcase
      for (i = 0; i < sfd_pkg::FRAME_BYTES; i++) begin
        b = sfd_pkg::BYTE_W'($urandom_range(0, 255));
        if (i == 0 && kind != FRAME_NOISE) begin
          if (kind == FRAME_BAD_HEADER) begin
            while (b == sfd_pkg::HEADER_BYTE) b = sfd_pkg::BYTE_W'($urandom_range(0, 255));
          end else begin
            b = sfd_pkg::HEADER_BYTE;
          end
        end else if (i == sfd_pkg::FRAME_BYTES - 1 && kind != FRAME_NOISE) begin
          if (kind == FRAME_BAD_FOOTER) begin
            while (b == sfd_pkg::FOOTER_BYTE) b = sfd_pkg::BYTE_W'($urandom_range(0, 255));
          end else begin
            b = sfd_pkg::FOOTER_BYTE;
          end
        end
        push_byte(b);
      end
    end

    // Let the last frame drain, then watch for stray words
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d decoded frames and %0d rejected frames, %0d channel words checked",
             sb.frames_good, sb.frames_dropped, sb.words_checked);
    $display("%0d mismatches over %0d cycles", sb.errors, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
